/* src/nk_pkg.sv */
package nk_pkg;

	localparam int unsigned ROUND_COUNT_DEF = 16;
	localparam int unsigned ROUND_MAX = 16;
	localparam int unsigned WORD_W = 32;
	localparam int unsigned RC_W = 8;
	localparam int unsigned CFG_INDEX_W = 3;
	localparam int unsigned KEY_WORDS = 4;

	typedef logic [WORD_W-1:0] word_t;
	typedef word_t [3:0] block_t;

	typedef struct packed {
		logic valid;
		logic mode;
	} ctl_t;

	typedef enum logic [1:0] {
		STAGE_CAPTURE,
		STAGE_ROUND,
		STAGE_FINAL
	} stage_kind_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_KEY_WORD_0 = 3'd0,
		REG_KEY_WORD_1 = 3'd1,
		REG_KEY_WORD_2 = 3'd2,
		REG_KEY_WORD_3 = 3'd3
	} cfg_reg_t;

	function automatic logic [RC_W-1:0] rc_const(input int unsigned idx);
		logic [RC_W-1:0] c;
		case (idx)
			0:       c = 8'h80;
			1:       c = 8'h1B;
			2:       c = 8'h36;
			3:       c = 8'h6C;
			4:       c = 8'hD8;
			5:       c = 8'hAB;
			6:       c = 8'h4D;
			7:       c = 8'h9A;
			8:       c = 8'h2F;
			9:       c = 8'h5E;
			10:      c = 8'hBC;
			11:      c = 8'h63;
			12:      c = 8'hC6;
			13:      c = 8'h97;
			14:      c = 8'h35;
			15:      c = 8'h6A;
			16:      c = 8'hD4;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	function automatic word_t rotl(input word_t v, input int unsigned n);
		return (v << n) | (v >> (WORD_W - n));
	endfunction

	function automatic word_t rotr(input word_t v, input int unsigned n);
		return (v >> n) | (v << (WORD_W - n));
	endfunction

	function automatic word_t mix8(input word_t t);
		return t ^ rotr(t, 8) ^ rotl(t, 8);
	endfunction

	function automatic block_t theta(input block_t k, input block_t a);
		block_t r;
		word_t t;
		r = a;
		t = mix8(r[0] ^ r[2]);
		r[1] = r[1] ^ t;
		r[3] = r[3] ^ t;
		r = r ^ k;
		t = mix8(r[1] ^ r[3]);
		r[0] = r[0] ^ t;
		r[2] = r[2] ^ t;
		return r;
	endfunction

	function automatic block_t gamma_nl(input block_t a);
		block_t r;
		word_t t;
		r = a;
		r[1] = r[1] ^ (~r[3] & ~r[2]);
		r[0] = r[0] ^ (r[2] & r[1]);
		t = r[3];
		r[3] = r[0];
		r[0] = t;
		r[2] = r[2] ^ r[0] ^ r[1] ^ r[3];
		r[1] = r[1] ^ (~r[3] & ~r[2]);
		r[0] = r[0] ^ (r[2] & r[1]);
		return r;
	endfunction

endpackage

/* src/nk_key.sv */
module nk_key (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [nk_pkg::CFG_INDEX_W-1:0]      cfg_index,
	input  nk_pkg::word_t                       cfg_data,
	output nk_pkg::block_t                      key,
	output nk_pkg::block_t                      ikey
);

	nk_pkg::block_t key_q;
	nk_pkg::block_t zero_key;

	assign cfg_ready = 1'b1;
	assign zero_key = '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				nk_pkg::REG_KEY_WORD_0: key_q[0] <= cfg_data;
				nk_pkg::REG_KEY_WORD_1: key_q[1] <= cfg_data;
				nk_pkg::REG_KEY_WORD_2: key_q[2] <= cfg_data;
				nk_pkg::REG_KEY_WORD_3: key_q[3] <= cfg_data;
				default: ;
			endcase
		end
	end

	assign key = key_q;
	// decrypt key is theta of the working key under an all-zero key
	assign ikey = nk_pkg::theta(zero_key, key_q);

endmodule

/* src/nk_stage.sv */
module nk_stage #(
	parameter nk_pkg::stage_kind_t KIND = nk_pkg::STAGE_ROUND,
	parameter logic [nk_pkg::RC_W-1:0] ENC_RC = '0,
	parameter logic [nk_pkg::RC_W-1:0] DEC_RC = '0
) (
	input  logic           clk,
	input  logic           arst_n,
	input  nk_pkg::ctl_t   in_ctl,
	input  nk_pkg::block_t in_blk,
	output logic           in_ready,
	output nk_pkg::ctl_t   out_ctl,
	output nk_pkg::block_t out_blk,
	input  logic           out_ready,
	input  nk_pkg::block_t key,
	input  nk_pkg::block_t ikey
);

	nk_pkg::ctl_t   ctl_s1;
	nk_pkg::block_t blk_s1;
	nk_pkg::block_t nxt;

	always_comb begin
		nk_pkg::block_t a;
		nk_pkg::block_t k;
		nk_pkg::word_t c1;
		nk_pkg::word_t c2;
		a = in_blk;
		k = in_ctl.mode ? ikey : key;
		// encrypt adds the constant before theta, decrypt after it
		c1 = in_ctl.mode ? '0 : {{(nk_pkg::WORD_W-nk_pkg::RC_W){1'b0}}, ENC_RC};
		c2 = in_ctl.mode ? {{(nk_pkg::WORD_W-nk_pkg::RC_W){1'b0}}, DEC_RC} : '0;
		if (KIND != nk_pkg::STAGE_CAPTURE) begin
			a[0] = a[0] ^ c1;
			a = nk_pkg::theta(k, a);
			a[0] = a[0] ^ c2;
		end
		if (KIND == nk_pkg::STAGE_ROUND) begin
			a[1] = nk_pkg::rotl(a[1], 1);
			a[2] = nk_pkg::rotl(a[2], 5);
			a[3] = nk_pkg::rotl(a[3], 2);
			a = nk_pkg::gamma_nl(a);
			a[1] = nk_pkg::rotr(a[1], 1);
			a[2] = nk_pkg::rotr(a[2], 5);
			a[3] = nk_pkg::rotr(a[3], 2);
		end
		nxt = a;
	end

	// a bubble here can always be filled
	assign in_ready = !ctl_s1.valid || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (in_ready) begin
			ctl_s1 <= in_ctl;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_ctl.valid) begin
			blk_s1 <= nxt;
		end
	end

	assign out_ctl = ctl_s1;
	assign out_blk = blk_s1;

endmodule

/* src/noekeon_block_cipher.sv */
// noekeon block cipher, direct-key mode, one 128-bit block per item
//
// input channel: in_valid / in_stall carry mode (0 encrypt, 1 decrypt) and
// block_word_0..3. output channel: out_valid / out_stall carry out_word_0..3.
// an item moves when valid is high and stall is low at a rising clk edge.
// key port: cfg_valid / cfg_ready with cfg_index 0..3 selecting key word
// 0..3 and cfg_data; other indexes are dropped. cfg_ready is always high.
// write the key only while no item is in flight.
//
// path: an accepted item passes an input register, one register per round
// and one for the closing theta before out_valid rises.
// throughput: one item per cycle while out_stall is low; each stage holds one item.
// out_stall backs up the pipeline stage by stage; empty stages still fill,
// and in_stall rises only once every stage holds an item.
// reset (arst_n low) clears the key to zero and empties the pipeline.
module noekeon_block_cipher #(
	parameter int unsigned ROUND_COUNT = nk_pkg::ROUND_COUNT_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic                           mode,
	input  logic [31:0]                    block_word_0,
	input  logic [31:0]                    block_word_1,
	input  logic [31:0]                    block_word_2,
	input  logic [31:0]                    block_word_3,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [31:0]                    out_word_0,
	output logic [31:0]                    out_word_1,
	output logic [31:0]                    out_word_2,
	output logic [31:0]                    out_word_3,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [nk_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [31:0]                    cfg_data
);

	localparam int unsigned RN = (ROUND_COUNT > nk_pkg::ROUND_MAX) ? nk_pkg::ROUND_MAX :
		((ROUND_COUNT < 1) ? 1 : ROUND_COUNT);
	localparam int unsigned NSTG = RN + 2;

	nk_pkg::block_t key;
	nk_pkg::block_t ikey;
	nk_pkg::ctl_t   ctl [NSTG+1];
	nk_pkg::block_t blk [NSTG+1];
	logic           rdy [NSTG+1];

	nk_key u_key (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.key       (key),
		.ikey      (ikey)
	);

	assign ctl[0].valid = in_valid;
	assign ctl[0].mode  = mode;
	assign blk[0]       = {block_word_3, block_word_2, block_word_1, block_word_0};
	assign rdy[NSTG]    = !out_stall;

	nk_stage #(
		.KIND   (nk_pkg::STAGE_CAPTURE),
		.ENC_RC ('0),
		.DEC_RC ('0)
	) u_capture (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ctl    (ctl[0]),
		.in_blk    (blk[0]),
		.in_ready  (rdy[0]),
		.out_ctl   (ctl[1]),
		.out_blk   (blk[1]),
		.out_ready (rdy[1]),
		.key       (key),
		.ikey      (ikey)
	);

	for (genvar i = 1; i <= RN; i++) begin : g_round
		// round i: encrypt uses constant i-1, decrypt runs them backward
		nk_stage #(
			.KIND   (nk_pkg::STAGE_ROUND),
			.ENC_RC (nk_pkg::rc_const(i - 1)),
			.DEC_RC (nk_pkg::rc_const(RN - i + 1))
		) u_round (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_ctl    (ctl[i]),
			.in_blk    (blk[i]),
			.in_ready  (rdy[i]),
			.out_ctl   (ctl[i+1]),
			.out_blk   (blk[i+1]),
			.out_ready (rdy[i+1]),
			.key       (key),
			.ikey      (ikey)
		);
	end

	nk_stage #(
		.KIND   (nk_pkg::STAGE_FINAL),
		.ENC_RC (nk_pkg::rc_const(RN)),
		.DEC_RC (nk_pkg::rc_const(0))
	) u_final (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ctl    (ctl[NSTG-1]),
		.in_blk    (blk[NSTG-1]),
		.in_ready  (rdy[NSTG-1]),
		.out_ctl   (ctl[NSTG]),
		.out_blk   (blk[NSTG]),
		.out_ready (rdy[NSTG]),
		.key       (key),
		.ikey      (ikey)
	);

	assign in_stall   = !rdy[0];
	assign out_valid  = ctl[NSTG].valid;
	assign out_word_0 = blk[NSTG][0];
	assign out_word_1 = blk[NSTG][1];
	assign out_word_2 = blk[NSTG][2];
	assign out_word_3 = blk[NSTG][3];

`ifndef SYNTHESIS
	a_stall_needs_full_out: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("input stalled while output side can drain");

	a_accept_fills_capture: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> ctl[1].valid)
		else $error("accepted item missing from capture stage");

	a_capture_mode_kept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (ctl[1].mode == $past(mode)))
		else $error("mode bit lost at capture");

	a_hold_when_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl[1].valid && !rdy[1]) |=> (ctl[1].valid && $stable(blk[1])))
		else $error("stalled capture stage changed");
`endif

endmodule

/* sim/tb_noekeon_block_cipher.sv */
module tb_noekeon_block_cipher;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned ROUNDS = nk_pkg::ROUND_COUNT_DEF;
	localparam int unsigned RUN_ROUNDS = (ROUNDS > nk_pkg::ROUND_MAX) ? nk_pkg::ROUND_MAX :
		((ROUNDS < 1) ? 1 : ROUNDS);
	localparam int unsigned RANDOM_BLOCKS_PER_KEY = 154;
	localparam int unsigned LONG_HOLD = 80;
	localparam int unsigned QUIET_LIMIT = 2000;

	// round constant sequence, entry 0 in the low byte
	localparam logic [16:0][7:0] RC_SEQ = {
		8'hD4, 8'h6A, 8'h35, 8'h97, 8'hC6, 8'h63, 8'hBC, 8'h5E, 8'h2F,
		8'h9A, 8'h4D, 8'hAB, 8'hD8, 8'h6C, 8'h36, 8'h1B, 8'h80
	};

	typedef struct {
		logic           mode;
		nk_pkg::block_t blk;
	} cipher_item_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic mode = 1'b0;
	logic [31:0] block_word_0 = '0;
	logic [31:0] block_word_1 = '0;
	logic [31:0] block_word_2 = '0;
	logic [31:0] block_word_3 = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [31:0] out_word_0;
	logic [31:0] out_word_1;
	logic [31:0] out_word_2;
	logic [31:0] out_word_3;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [nk_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;

	cipher_item_t block_queue[$];
	nk_pkg::block_t cipher_expect[$];
	nk_pkg::block_t key_shadow = '0;
	int unsigned blocks_queued = 0;
	int unsigned results_seen = 0;
	int unsigned mismatches = 0;
	int unsigned send_idle_pct = 0;
	int unsigned recv_idle_pct = 0;
	int unsigned hold_requests = 0;
	int unsigned quiet_cycles = 0;

	noekeon_block_cipher #(
		.ROUND_COUNT(ROUNDS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.mode(mode),
		.block_word_0(block_word_0),
		.block_word_1(block_word_1),
		.block_word_2(block_word_2),
		.block_word_3(block_word_3),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_word_0(out_word_0),
		.out_word_1(out_word_1),
		.out_word_2(out_word_2),
		.out_word_3(out_word_3),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic nk_pkg::word_t rol32(input nk_pkg::word_t v, input int unsigned n);
		logic [63:0] d;
		d = {v, v} << n;
		return d[63:32];
	endfunction

	function automatic nk_pkg::word_t ror32(input nk_pkg::word_t v, input int unsigned n);
		logic [63:0] d;
		d = {v, v} >> n;
		return d[31:0];
	endfunction

	function automatic nk_pkg::word_t spread8(input nk_pkg::word_t t);
		return t ^ ror32(t, 8) ^ rol32(t, 8);
	endfunction

	function automatic nk_pkg::block_t theta_mix(input nk_pkg::block_t k,
		input nk_pkg::block_t a);
		nk_pkg::block_t r;
		nk_pkg::word_t t;
		r = a;
		t = spread8(r[0] ^ r[2]);
		r[1] = r[1] ^ t;
		r[3] = r[3] ^ t;
		for (int i = 0; i < 4; i++) begin
			r[i] = r[i] ^ k[i];
		end
		t = spread8(r[1] ^ r[3]);
		r[0] = r[0] ^ t;
		r[2] = r[2] ^ t;
		return r;
	endfunction

	function automatic nk_pkg::block_t gamma_layer(input nk_pkg::block_t a);
		nk_pkg::block_t r;
		nk_pkg::word_t t;
		r = a;
		r[1] = r[1] ^ (~r[3] & ~r[2]);
		r[0] = r[0] ^ (r[2] & r[1]);
		t = r[3];
		r[3] = r[0];
		r[0] = t;
		r[2] = r[2] ^ r[0] ^ r[1] ^ r[3];
		r[1] = r[1] ^ (~r[3] & ~r[2]);
		r[0] = r[0] ^ (r[2] & r[1]);
		return r;
	endfunction

	function automatic nk_pkg::block_t cipher_round(input nk_pkg::block_t k,
		input nk_pkg::block_t a, input logic [7:0] pre_rc, input logic [7:0] post_rc);
		nk_pkg::block_t r;
		r = a;
		r[0] = r[0] ^ nk_pkg::word_t'(pre_rc);
		r = theta_mix(k, r);
		r[0] = r[0] ^ nk_pkg::word_t'(post_rc);
		r[1] = rol32(r[1], 1);
		r[2] = rol32(r[2], 5);
		r[3] = rol32(r[3], 2);
		r = gamma_layer(r);
		r[1] = ror32(r[1], 1);
		r[2] = ror32(r[2], 5);
		r[3] = ror32(r[3], 2);
		return r;
	endfunction

	function automatic nk_pkg::block_t noekeon_predict(input logic dir,
		input nk_pkg::block_t blk, input nk_pkg::block_t k);
		nk_pkg::block_t a;
		nk_pkg::block_t inv_key;
		int unsigned i;
		a = blk;
		if (!dir) begin
			for (i = 0; i < RUN_ROUNDS; i++) begin
				a = cipher_round(k, a, RC_SEQ[i], 8'h00);
			end
			a[0] = a[0] ^ nk_pkg::word_t'(RC_SEQ[RUN_ROUNDS]);
			a = theta_mix(k, a);
		end else begin
			// decryption runs under theta of the key with a zero key
			inv_key = theta_mix('0, k);
			for (i = RUN_ROUNDS; i > 0; i--) begin
				a = cipher_round(inv_key, a, 8'h00, RC_SEQ[i]);
			end
			a = theta_mix(inv_key, a);
			a[0] = a[0] ^ nk_pkg::word_t'(RC_SEQ[0]);
		end
		return a;
	endfunction

	task automatic report_mismatch(input string what, input nk_pkg::word_t got,
		input nk_pkg::word_t want);
		mismatches++;
		$display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
	endtask

	function automatic nk_pkg::word_t rand_word();
		nk_pkg::word_t w;
		case ($urandom_range(7))
			0: w = '0;
			1: w = '1;
			default: w = $urandom;
		endcase
		return w;
	endfunction

	task automatic push_block(input logic dir, input nk_pkg::word_t w0,
		input nk_pkg::word_t w1, input nk_pkg::word_t w2, input nk_pkg::word_t w3);
		cipher_item_t it;
		it.mode = dir;
		it.blk[0] = w0;
		it.blk[1] = w1;
		it.blk[2] = w2;
		it.blk[3] = w3;
		block_queue.push_back(it);
		blocks_queued++;
	endtask

	task automatic wait_drain();
		while (block_queue.size() != 0 || results_seen != blocks_queued) begin
			@(posedge clk);
		end
	endtask

	task automatic write_key_reg(input logic [nk_pkg::CFG_INDEX_W-1:0] idx,
		input nk_pkg::word_t data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		if (idx < nk_pkg::KEY_WORDS) begin
			key_shadow[idx[1:0]] = data;
		end
	endtask

	// key writes happen only with the pipeline empty
	task automatic load_key(input nk_pkg::word_t k0, input nk_pkg::word_t k1,
		input nk_pkg::word_t k2, input nk_pkg::word_t k3);
		wait_drain();
		write_key_reg(nk_pkg::REG_KEY_WORD_0, k0);
		write_key_reg(nk_pkg::REG_KEY_WORD_1, k1);
		write_key_reg(nk_pkg::REG_KEY_WORD_2, k2);
		write_key_reg(nk_pkg::REG_KEY_WORD_3, k3);
		// indexes past the key words must leave the key alone
		for (int j = 0; j < nk_pkg::KEY_WORDS; j++) begin
			write_key_reg((nk_pkg::CFG_INDEX_W)'(nk_pkg::KEY_WORDS + j), $urandom);
		end
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic queue_directed();
		push_block(1'b0, '0, '0, '0, '0);
		push_block(1'b1, '0, '0, '0, '0);
		push_block(1'b0, '1, '1, '1, '1);
		push_block(1'b1, '1, '1, '1, '1);
		push_block(1'b0, 32'hAAAAAAAA, 32'hAAAAAAAA, 32'hAAAAAAAA, 32'hAAAAAAAA);
		push_block(1'b1, 32'h55555555, 32'h55555555, 32'h55555555, 32'h55555555);
		push_block(1'b0, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000);
		push_block(1'b1, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000);
		push_block(1'b0, 32'h00000001, 32'h00000001, 32'h00000001, 32'h00000001);
		push_block(1'b1, 32'h00000001, 32'h00000001, 32'h00000001, 32'h00000001);
		push_block(1'b0, '0, '1, '0, '1);
		push_block(1'b1, '1, '0, '1, '0);
	endtask

	always @(posedge clk) begin : drive_blocks
		nk_pkg::block_t accepted;
		cipher_item_t nxt;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				accepted[0] = block_word_0;
				accepted[1] = block_word_1;
				accepted[2] = block_word_2;
				accepted[3] = block_word_3;
				cipher_expect.push_back(noekeon_predict(mode, accepted, key_shadow));
			end
			if (!in_valid || !in_stall) begin
				if (block_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					nxt = block_queue.pop_front();
					in_valid <= 1'b1;
					mode <= nxt.mode;
					block_word_0 <= nxt.blk[0];
					block_word_1 <= nxt.blk[1];
					block_word_2 <= nxt.blk[2];
					block_word_3 <= nxt.blk[3];
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin : check_results
		nk_pkg::block_t got;
		nk_pkg::block_t want;
		int unsigned hold_left;
		int unsigned hold_served;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				results_seen++;
				got[0] = out_word_0;
				got[1] = out_word_1;
				got[2] = out_word_2;
				got[3] = out_word_3;
				if (cipher_expect.size() == 0) begin
					report_mismatch("result with no block in flight, out_word_0", got[0], '0);
				end else begin
					want = cipher_expect.pop_front();
					for (int i = 0; i < 4; i++) begin
						if (got[i] !== want[i]) begin
							report_mismatch($sformatf("out_word_%0d", i), got[i], want[i]);
						end
					end
				end
			end
			// a long hold-off lets the pipeline fill and back up to the input
			if (hold_left != 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (hold_served != hold_requests) begin
				hold_served = hold_requests;
				hold_left = LONG_HOLD;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(99) < recv_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
			(cfg_valid && cfg_ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
		end
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("noekeon_block_cipher regression: fail");
			$finish;
		end
	end

	initial begin
		int phase;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 25;
		recv_idle_pct = 69;
		load_key('0, '0, '0, '0);
		queue_directed();
		load_key('1, '1, '1, '1);
		queue_directed();

		for (int s = 0; s < 3; s++) begin
			case (s)
				0: begin
					send_idle_pct = 25;
					recv_idle_pct = 69;
				end
				1: begin
					send_idle_pct = 69;
					recv_idle_pct = 25;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			for (int p = 0; p < 2; p++) begin
				phase = s * 2 + p;
				case (phase)
					1: load_key('1, '0, '1, '0);
					3: load_key(32'h00000001, '0, '0, 32'h80000000);
					default: load_key(rand_word(), rand_word(), rand_word(), rand_word());
				endcase
				if (s == 2 && p == 0) begin
					hold_requests++;
				end
				repeat (RANDOM_BLOCKS_PER_KEY) begin
					push_block(1'($urandom_range(1)), rand_word(), rand_word(), rand_word(),
						rand_word());
				end
			end
		end

		wait_drain();
		repeat (RUN_ROUNDS + 4) @(posedge clk);
		if (mismatches == 0) begin
			$display("noekeon_block_cipher regression: pass");
		end else begin
			$display("noekeon_block_cipher regression: fail");
		end
		$finish;
	end

endmodule
